>>> sv/ople_pkg.sv
// types and constants shared by the ordered list engine
// no dependencies
package ople_pkg;

   // request codes
   localparam logic [2:0] REQ_APPEND   = 3'd0;
   localparam logic [2:0] REQ_INSERT   = 3'd1;
   localparam logic [2:0] REQ_FIND     = 3'd2;
   localparam logic [2:0] REQ_RM_SHIFT = 3'd3;
   localparam logic [2:0] REQ_RM_SWAP  = 3'd4;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [5:0]  position;
      logic [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] removed_value;
      logic [5:0]  found_position;
      logic [6:0]  entry_count;
   } rsp_word_type;

   // operation broadcast to every cell, set only when the request will succeed
   // (find is always set, its hit comes back through the chain)
   typedef struct packed {
      logic ins;
      logic find;
      logic rm_shift;
      logic rm_swap;
   } cell_cmd_type;

endpackage

>>> sv/ople_cell.sv
// one list cell: holds one entry and passes the request token to the cell below
// depends on ople_pkg
module ople_cell #(
   parameter int IDX = 0,
   parameter int EW  = 32,
   parameter int IW  = 6,
   parameter int CW  = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ople_pkg::cell_cmd_type cmd,
   input  logic [IW-1:0]         tgt_idx,
   input  logic [IW-1:0]         last_idx,
   input  logic [CW-1:0]         cnt,
   input  logic [EW-1:0]         req_value,
   input  logic [EW-1:0]         below_data,
   input  logic                  act_in,
   input  logic [EW-1:0]         carry_in,
   input  logic [EW-1:0]         removed_in,
   input  logic                  found_in,
   input  logic [IW-1:0]         fidx_in,
   output logic [EW-1:0]         data_out,
   output logic                  act_out,
   output logic [EW-1:0]         carry_out,
   output logic [EW-1:0]         removed_out,
   output logic                  found_out,
   output logic [IW-1:0]         fidx_out
);
   import ople_pkg::*;

   localparam logic [IW-1:0] K_I = IW'(IDX);
   localparam logic [CW-1:0] K_C = CW'(IDX);

   logic [EW-1:0] data_ff, data_in;
   logic          act_ff;
   logic [EW-1:0] carry_ff, carry_in_nx;
   logic [EW-1:0] removed_ff, removed_in_nx;
   logic          found_ff, found_in_nx;
   logic [IW-1:0] fidx_ff, fidx_in_nx;

   always_comb begin
      data_in       = data_ff;
      carry_in_nx   = carry_in;
      removed_in_nx = removed_in;
      found_in_nx   = found_in;
      fidx_in_nx    = fidx_in;
      if (act_in) begin
         if (cmd.ins) begin
            // entries from the target up move one place up
            if (K_I == tgt_idx) begin
               data_in = req_value;
            end else if (K_I > tgt_idx && K_C <= cnt) begin
               data_in = below_data;
            end
         end
         if (cmd.find && K_C < cnt && data_ff == req_value) begin
            found_in_nx = 1'b1;
            fidx_in_nx  = K_I;
         end
         if (cmd.rm_shift && K_I >= tgt_idx && K_C < cnt) begin
            // token walks down carrying the entry from above
            carry_in_nx = data_ff;
            data_in     = carry_in;
            if (K_I == tgt_idx) begin
               removed_in_nx = data_ff;
            end
         end
         if (cmd.rm_swap) begin
            if (K_I == last_idx) begin
               carry_in_nx = data_ff;
            end
            if (K_I == tgt_idx) begin
               removed_in_nx = data_ff;
               data_in       = carry_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff    <= data_in;
      carry_ff   <= carry_in_nx;
      removed_ff <= removed_in_nx;
      found_ff   <= found_in_nx;
      fidx_ff    <= fidx_in_nx;
   end

   assign data_out    = data_ff;
   assign act_out     = act_ff;
   assign carry_out   = carry_ff;
   assign removed_out = removed_ff;
   assign found_out   = found_ff;
   assign fidx_out    = fidx_ff;

endmodule

>>> sv/ordered_pointer_list_engine.sv
// ordered list engine: request decode, entry count and the row of list cells
// depends on ople_pkg and ople_cell
//
// a new request is accepted only when no walk is in flight and the response
//   register is free or being taken; the request token walks the row of cells
//   from the top cell down to entry 0, one cell per cycle
// reset: clears the entry count and all handshake state; entries stay undefined
//   and are never read before they are written
module ordered_pointer_list_engine #(
   parameter int CAPACITY      = 64,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ople_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ople_pkg::rsp_word_type rsp_word
);
   import ople_pkg::*;

   localparam int EW = ELEMENT_WIDTH;
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   // width for comparing the 6-bit position against the count
   localparam int MW = (CW > 6) ? CW : 6;
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   // control state
   logic          busy_ff, busy_in;
   logic          start_ff, start_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // request held for the whole walk
   cell_cmd_type  cmd_ff, cmd_in;
   logic [IW-1:0] tgt_ff, tgt_in;
   logic [IW-1:0] last_ff, last_in;
   logic [EW-1:0] value_ff, value_in;
   rsp_word_type  rsp_word_ff, rsp_word_in;

   // links between cells, index k is the output of cell k, CAPACITY is the head
   logic [EW-1:0] cell_data [CAPACITY];
   logic          act_link     [CAPACITY+1];
   logic [EW-1:0] carry_link   [CAPACITY+1];
   logic [EW-1:0] removed_link [CAPACITY+1];
   logic          found_link   [CAPACITY+1];
   logic [IW-1:0] fidx_link    [CAPACITY+1];

   logic          req_fire;
   logic          chain_done;
   logic          full;
   logic          pos_in_range;
   logic [MW-1:0] pos_m, cnt_m;

   assign req_ready  = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_fire   = req_valid && req_ready;
   assign chain_done = act_link[0];

   assign full         = (count_ff == FULL_COUNT);
   assign pos_m        = MW'(req_word.position);
   assign cnt_m        = MW'(count_ff);
   assign pos_in_range = (pos_m < cnt_m);

   // decode the request against the current count
   always_comb begin
      cmd_in   = cmd_ff;
      tgt_in   = tgt_ff;
      last_in  = last_ff;
      value_in = value_ff;
      if (req_fire) begin
         cmd_in   = '0;
         value_in = EW'(req_word.value);
         last_in  = IW'(count_ff - CW'(1));
         tgt_in   = IW'(req_word.position);
         unique case (req_word.req_type)
            REQ_APPEND: begin
               cmd_in.ins = !full;
               tgt_in     = IW'(count_ff);
            end
            REQ_INSERT: begin
               // an index at or past the end appends
               cmd_in.ins = !full;
               if (!pos_in_range) begin
                  tgt_in = IW'(count_ff);
               end
            end
            REQ_FIND: begin
               cmd_in.find = 1'b1;
            end
            REQ_RM_SHIFT: begin
               cmd_in.rm_shift = pos_in_range;
            end
            REQ_RM_SWAP: begin
               cmd_in.rm_swap = pos_in_range;
            end
            default: begin
               // unused codes walk the chain with no operation
            end
         endcase
      end
   end

   // token injected at the top cell with an empty carry
   assign act_link[CAPACITY]     = start_ff;
   assign carry_link[CAPACITY]   = '0;
   assign removed_link[CAPACITY] = '0;
   assign found_link[CAPACITY]   = 1'b0;
   assign fidx_link[CAPACITY]    = '0;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      logic [EW-1:0] below;
      if (k == 0) begin : g_bottom
         assign below = '0;
      end else begin : g_mid
         assign below = cell_data[k-1];
      end
      ople_cell #(
         .IDX (k),
         .EW  (EW),
         .IW  (IW),
         .CW  (CW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd_ff),
         .tgt_idx     (tgt_ff),
         .last_idx    (last_ff),
         .cnt         (count_ff),
         .req_value   (value_ff),
         .below_data  (below),
         .act_in      (act_link[k+1]),
         .carry_in    (carry_link[k+1]),
         .removed_in  (removed_link[k+1]),
         .found_in    (found_link[k+1]),
         .fidx_in     (fidx_link[k+1]),
         .data_out    (cell_data[k]),
         .act_out     (act_link[k]),
         .carry_out   (carry_link[k]),
         .removed_out (removed_link[k]),
         .found_out   (found_link[k]),
         .fidx_out    (fidx_link[k])
      );
   end

   // completion: update the count and build the response word
   always_comb begin
      busy_in      = busy_ff;
      start_in     = req_fire;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end
      if (chain_done) begin
         busy_in = 1'b0;
         if (cmd_ff.ins) begin
            count_in = count_ff + CW'(1);
         end else if (cmd_ff.rm_shift || cmd_ff.rm_swap) begin
            count_in = count_ff - CW'(1);
         end
         rsp_valid_in               = 1'b1;
         rsp_word_in.ok             = cmd_ff.find ? found_link[0]
                                      : (cmd_ff.ins || cmd_ff.rm_shift || cmd_ff.rm_swap);
         rsp_word_in.removed_value  = 32'(removed_link[0]);
         rsp_word_in.found_position = found_link[0] ? 6'(fidx_link[0]) : 6'd0;
         rsp_word_in.entry_count    = 7'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         start_ff     <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      tgt_ff      <= tgt_in;
      last_ff     <= last_in;
      value_ff    <= value_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a finished walk always finds the response register free
   a_done_slot_free: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> !rsp_valid_ff)
      else $error("walk finished while response still pending");

   // the walk only finishes while a request is in flight
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      chain_done |-> busy_ff)
      else $error("walk finished with no request in flight");

   // the count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count beyond capacity");

   // an accepted request starts a walk on the next cycle
   a_start: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (start_ff && busy_ff))
      else $error("accepted request did not start");

endmodule
